// ----- rtl/core/udpdmx_pkg.sv -----
// Package with command, status, state and payload types of the UDP port demultiplexer.
`default_nettype none
package udpdmx_pkg;

    typedef enum logic [1:0] {
        CMD_BIND  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_RECV  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_FULL   = 4'd1,
        ST_NOSOCK = 4'd2,
        ST_EMPTY  = 4'd3,
        ST_SHORT  = 4'd4,
        ST_NOTUDP = 4'd5,
        ST_BADLEN = 4'd6,
        ST_QFULL  = 4'd7,
        ST_ARP    = 4'd8,
        ST_OTHER  = 4'd9
    } status_t;

    localparam logic [15:0] TYPE_IP   = 16'h0800;
    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [12:0] LEN_ARP   = 13'd42;
    localparam logic [12:0] LEN_IP    = 13'd34;
    localparam logic [12:0] LEN_UDP   = 13'd42;
    localparam logic [15:0] UDP_HDR   = 16'd8;

    // Bits of the buffer handle kept in a queued descriptor.
    localparam int BUFFER_ID_BITS = 8;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [12:0] frame_len;
        logic [15:0] eth_type;
        logic [7:0]  ip_proto;
        logic [15:0] udp_dest_port;
        logic [15:0] udp_src_port;
        logic [15:0] udp_length;
        logic [31:0] source_ip;
        logic [7:0]  buffer_id;
        logic [15:0] max_len;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] out_src_ip;
        logic [15:0] out_src_port;
        logic [15:0] xfer_len;
        logic [7:0]  out_buffer_id;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_READ,
        S_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic act;
        logic rd_issue;
        logic rd_finish;
        logic out_take;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic need_read;
        logic out_valid;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/udp_port_demux_queues_unit.sv -----
// Top level of the UDP port demultiplexer with per-port receive queues.
// A command is accepted in the idle state, then passes through the slot-by-slot table scan,
// the update step and, for a successful recv, the registered read of the descriptor memory.
// No new command is taken until the controller is back in idle and the last result is leaving.
// Reset clears slot valid bits, queue pointers and the controller; descriptor memory
// needs no clearing since only counted entries are ever read.
`default_nettype none
module udp_port_demux_queues_unit #(
    parameter int SOCKET_COUNT   = 16,
    parameter int QUEUE_DEPTH    = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire udpdmx_pkg::in_item_t   in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output udpdmx_pkg::out_item_t       out_data
);
    import udpdmx_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller walks each beat through scan, update and optional memory read.
    udpdmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the table, queues and the output register.
    udpdmx_dp #(
        .SOCKET_COUNT   (SOCKET_COUNT),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_data)
    );

    assign out_valid = stat.out_valid;
endmodule
`default_nettype wire

// ----- rtl/core/udpdmx_ctrl.sv -----
// Controller state machine sequencing scan, update, queue read and result delivery.
`default_nettype none
module udpdmx_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  out_ready,
    input  wire udpdmx_pkg::dp_stat_t  stat,
    output udpdmx_pkg::dp_cmd_t        cmd
);
    import udpdmx_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cmd.out_take = stat.out_valid && out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                // A new item may enter once the previous result has been taken or is leaving.
                in_ready = !stat.out_valid || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                cmd.act = 1'b1;
                if (stat.need_read)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                cmd.rd_finish = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/udpdmx_dp.sv -----
// Datapath: socket table, queue pointers, descriptor memory and result register.
`default_nettype none
module udpdmx_dp #(
    parameter int SOCKET_COUNT   = 16,
    parameter int QUEUE_DEPTH    = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire udpdmx_pkg::in_item_t  in_item,
    input  wire udpdmx_pkg::dp_cmd_t   cmd,
    output udpdmx_pkg::dp_stat_t       stat,
    output udpdmx_pkg::out_item_t      out_item
);
    import udpdmx_pkg::*;

    localparam int SW = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = SW + QW;
    localparam int ENTRIES = 1 << EW;
    localparam int MW = 16 + 16 + BUFFER_ID_BITS;
    localparam int SCW = $clog2(SOCKET_COUNT + 1);

    logic [SOCKET_COUNT-1:0] used_reg;
    logic [15:0]             port_reg  [SOCKET_COUNT];
    logic [QW-1:0]           head_reg  [SOCKET_COUNT];
    logic [CW-1:0]           count_reg [SOCKET_COUNT];

    logic [31:0]   ip_mem   [ENTRIES];
    logic [MW-1:0] meta_mem [ENTRIES];

    in_item_t       item_reg;
    logic [SCW-1:0] idx_reg;
    logic           hit_reg, free_reg;
    logic [SW-1:0]  hit_slot_reg, free_slot_reg;
    logic [31:0]    rd_ip_reg;
    logic [MW-1:0]  rd_meta_reg;
    out_item_t      out_reg;
    logic           out_valid_reg;

    logic [SW-1:0]  idx;
    logic           scan_done;
    assign idx       = idx_reg[SW-1:0];
    assign scan_done = (idx_reg == SCW'(SOCKET_COUNT - 1));

    // Port compared at each scan step: the frame's destination for frame commands.
    logic [15:0] key;
    assign key = (item_reg.cmd == CMD_FRAME) ? item_reg.udp_dest_port : item_reg.port;

    // Frame header checks, independent of the table.
    logic [3:0] pre_st;
    logic       pre_pass;
    always_comb begin
        pre_pass = 1'b0;
        pre_st   = ST_OK;
        if (item_reg.eth_type == TYPE_ARP)
        begin
            pre_st = (item_reg.frame_len >= LEN_ARP) ? ST_ARP : ST_SHORT;
        end
        else if (item_reg.eth_type != TYPE_IP)
        begin
            pre_st = ST_OTHER;
        end
        else if (item_reg.frame_len < LEN_IP)
        begin
            pre_st = ST_SHORT;
        end
        else if (item_reg.ip_proto != PROTO_UDP)
        begin
            pre_st = ST_NOTUDP;
        end
        else if (item_reg.frame_len < LEN_UDP)
        begin
            pre_st = ST_SHORT;
        end
        else if (item_reg.udp_length < UDP_HDR)
        begin
            pre_st = ST_BADLEN;
        end
        else
        begin
            pre_pass = 1'b1;
        end
    end

    logic [QW-1:0] hhead;
    logic [CW-1:0] hcount;
    logic [QW-1:0] wr_pos;
    logic [QW:0]   pos_sum;
    logic [EW-1:0] wr_addr, rd_addr;
    assign hhead   = head_reg[hit_slot_reg];
    assign hcount  = count_reg[hit_slot_reg];
    assign pos_sum = (QW+1)'(hhead) + (QW+1)'(hcount);
    assign wr_pos  = (pos_sum >= (QW+1)'(QUEUE_DEPTH))
                   ? QW'(pos_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(pos_sum);
    assign wr_addr = EW'({hit_slot_reg, wr_pos});
    assign rd_addr = EW'({hit_slot_reg, hhead});

    logic [QW-1:0] head_inc;
    assign head_inc = (hhead == QW'(QUEUE_DEPTH - 1)) ? '0 : hhead + 1'b1;

    logic [15:0] plen, rlen;
    assign plen = rd_meta_reg[BUFFER_ID_BITS +: 16];
    assign rlen = (plen < item_reg.max_len) ? plen : item_reg.max_len;

    logic push_ok, pop_ok, do_push, do_pop;
    assign push_ok = item_reg.cmd == CMD_FRAME && pre_pass && hit_reg
                   && hcount != CW'(QUEUE_DEPTH);
    assign pop_ok  = item_reg.cmd == CMD_RECV && hit_reg && hcount != '0;
    assign do_push = cmd.act && push_ok;
    assign do_pop  = cmd.act && pop_ok;

    // Result of the update step; a successful recv fills in its fields after the read.
    out_item_t act_res;
    always_comb begin
        act_res = '0;
        case (item_reg.cmd)
            CMD_BIND:
            begin
                act_res.status = (hit_reg || free_reg) ? ST_OK : ST_FULL;
            end
            CMD_FRAME:
            begin
                act_res.out_buffer_id = item_reg.buffer_id;
                if (!pre_pass)
                begin
                    act_res.status = pre_st;
                end
                else if (!hit_reg)
                begin
                    act_res.status = ST_NOSOCK;
                end
                else if (hcount == CW'(QUEUE_DEPTH))
                begin
                    act_res.status = ST_QFULL;
                end
                else
                begin
                    act_res.status        = ST_OK;
                    act_res.out_buffer_id = '0;
                end
            end
            CMD_RECV:
            begin
                if (!hit_reg)
                begin
                    act_res.status = ST_NOSOCK;
                end
                else if (hcount == '0)
                begin
                    act_res.status = ST_EMPTY;
                end
                else
                begin
                    act_res.status = ST_OK;
                end
            end
            default:
            begin
                act_res.status = ST_OTHER;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (do_push)
        begin
            ip_mem[wr_addr]   <= item_reg.source_ip;
            meta_mem[wr_addr] <= {item_reg.udp_src_port, item_reg.udp_length - UDP_HDR,
                                  item_reg.buffer_id[BUFFER_ID_BITS-1:0]};
        end
        if (cmd.rd_issue)
        begin
            rd_ip_reg   <= ip_mem[rd_addr];
            rd_meta_reg <= meta_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            hit_slot_reg  <= '0;
            free_slot_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < SOCKET_COUNT; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                port_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.scan_clear)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                // First hit and first free slot, walking up from slot zero.
                if (used_reg[idx] && port_reg[idx] == key && !hit_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= idx;
                end
                if (!used_reg[idx] && !free_reg)
                begin
                    free_reg      <= 1'b1;
                    free_slot_reg <= idx;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.act)
            begin
                out_reg       <= act_res;
                out_valid_reg <= !pop_ok;
                if (item_reg.cmd == CMD_BIND && !hit_reg && free_reg)
                begin
                    used_reg[free_slot_reg]  <= 1'b1;
                    port_reg[free_slot_reg]  <= item_reg.port;
                    head_reg[free_slot_reg]  <= '0;
                    count_reg[free_slot_reg] <= '0;
                end
                if (do_push)
                begin
                    count_reg[hit_slot_reg] <= hcount + 1'b1;
                end
                if (do_pop)
                begin
                    head_reg[hit_slot_reg]  <= head_inc;
                    count_reg[hit_slot_reg] <= hcount - 1'b1;
                end
            end
            if (cmd.rd_finish)
            begin
                out_reg.out_src_ip    <= rd_ip_reg;
                out_reg.out_src_port  <= rd_meta_reg[MW-1 -: 16];
                out_reg.xfer_len      <= rlen;
                out_reg.out_buffer_id <= 8'(rd_meta_reg[BUFFER_ID_BITS-1:0]);
                out_valid_reg         <= 1'b1;
            end
        end
    end

    assign stat.scan_done = scan_done;
    assign stat.need_read = pop_ok;
    assign stat.out_valid = out_valid_reg;
    assign out_item       = out_reg;
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the UDP port demultiplexer with per-port receive queues.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import udpdmx_pkg::*;

    localparam int SOCKETS = 16;
    localparam int DEPTH = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    udp_port_demux_queues_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the socket table and the per-slot descriptor rings.
    logic        sock_used [SOCKETS];
    logic [15:0] sock_port [SOCKETS];
    int          ring_head [SOCKETS];
    int          ring_count [SOCKETS];
    logic [31:0] ring_ip [SOCKETS][DEPTH];
    logic [15:0] ring_sport [SOCKETS][DEPTH];
    logic [15:0] ring_plen [SOCKETS][DEPTH];
    logic [7:0]  ring_bid [SOCKETS][DEPTH];

    out_item_t pending_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int status_hits [16];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int lookup_socket(logic [15:0] p);
        for (int i = 0; i < SOCKETS; i++)
            if (sock_used[i] && sock_port[i] == p)
                return i;
        return -1;
    endfunction

    function automatic status_t classify_frame(in_item_t it);
        if (it.eth_type == TYPE_ARP)
            return (it.frame_len >= 13'd42) ? ST_ARP : ST_SHORT;
        if (it.eth_type != TYPE_IP)
            return ST_OTHER;
        if (it.frame_len < 13'd34)
            return ST_SHORT;
        if (it.ip_proto != PROTO_UDP)
            return ST_NOTUDP;
        if (it.frame_len < 13'd42)
            return ST_SHORT;
        if (it.udp_length < 16'd8)
            return ST_BADLEN;
        return ST_OK;
    endfunction

    // Advances the shadow state by one command and returns the result it yields.
    function automatic out_item_t demux_step(in_item_t it);
        out_item_t r;
        int s;
        int pos;
        status_t st;
        r = '0;
        case (cmd_t'(it.cmd))
            CMD_BIND:
            begin
                r.status = ST_OK;
                if (lookup_socket(it.port) < 0)
                begin
                    r.status = ST_FULL;
                    for (int i = 0; i < SOCKETS; i++)
                        if (!sock_used[i] && r.status == ST_FULL)
                        begin
                            sock_used[i] = 1'b1;
                            sock_port[i] = it.port;
                            ring_head[i] = 0;
                            ring_count[i] = 0;
                            r.status = ST_OK;
                        end
                end
            end
            CMD_FRAME:
            begin
                st = classify_frame(it);
                if (st == ST_OK)
                begin
                    s = lookup_socket(it.udp_dest_port);
                    if (s < 0)
                        st = ST_NOSOCK;
                    else if (ring_count[s] >= DEPTH)
                        st = ST_QFULL;
                    else
                    begin
                        pos = (ring_head[s] + ring_count[s]) % DEPTH;
                        ring_ip[s][pos] = it.source_ip;
                        ring_sport[s][pos] = it.udp_src_port;
                        ring_plen[s][pos] = it.udp_length - 16'd8;
                        ring_bid[s][pos] = it.buffer_id;
                        ring_count[s]++;
                    end
                end
                r.status = st;
                r.out_buffer_id = (st == ST_OK) ? 8'd0 : it.buffer_id;
            end
            CMD_RECV:
            begin
                s = lookup_socket(it.port);
                if (s < 0)
                    r.status = ST_NOSOCK;
                else if (ring_count[s] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos = ring_head[s];
                    r.status = ST_OK;
                    r.out_src_ip = ring_ip[s][pos];
                    r.out_src_port = ring_sport[s][pos];
                    r.xfer_len = (ring_plen[s][pos] < it.max_len) ?
                                 ring_plen[s][pos] : it.max_len;
                    r.out_buffer_id = ring_bid[s][pos];
                    ring_head[s] = (pos + 1) % DEPTH;
                    ring_count[s]--;
                end
            end
            default:
                r.status = ST_OTHER;
        endcase
        return r;
    endfunction

    // Sends one beat; a known result, when given, is checked against the predictor too.
    // Valid stays high after the accepting edge until the next beat or an idle cycle.
    task automatic send_beat(in_item_t it, logic has_known, out_item_t known);
        out_item_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        predicted = demux_step(it);
        if (has_known && predicted !== known)
            $display("directed row disagrees with predictor: row %h pred %h",
                     known, predicted);
        pending_results.push_back(has_known ? known : predicted);
        in_data <= it;
        in_valid <= 1'b1;
        // Ready is stable from one rising edge to the next, so it is sampled mid-cycle.
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    // Receiver side: stalls at random and checks every result beat in order.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            status_hits[out_data.status]++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status || out_data.out_src_ip !== want.out_src_ip
                    || out_data.out_src_port !== want.out_src_port
                    || out_data.xfer_len !== want.xfer_len
                    || out_data.out_buffer_id !== want.out_buffer_id)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: status %0d/%0d ip %h/%h sport %h/%h",
                                  " len %h/%h bid %h/%h"},
                                 want.status, out_data.status, want.out_src_ip,
                                 out_data.out_src_ip, want.out_src_port, out_data.out_src_port,
                                 want.xfer_len, out_data.xfer_len, want.out_buffer_id,
                                 out_data.out_buffer_id);
                end
            end
        end
        out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    function automatic in_item_t make_item(cmd_t c, logic [15:0] p);
        in_item_t it;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.cmd = c;
        it.port = p;
        it.udp_dest_port = p;
        return it;
    endfunction

    function automatic in_item_t good_frame(logic [15:0] p);
        in_item_t it;
        it = make_item(CMD_FRAME, p);
        it.eth_type = TYPE_IP;
        it.ip_proto = PROTO_UDP;
        it.frame_len = 13'($urandom_range(4096, 42));
        it.udp_length = ($urandom_range(3) == 0) ? 16'($urandom_range(15, 8))
                                                 : 16'($urandom_range(65535, 8));
        return it;
    endfunction

    // Directed table: a command, and where it is obvious, the result it must give.
    typedef struct {
        in_item_t  beat;
        logic      has_known;
        out_item_t known;
    } dir_row_t;

    dir_row_t directed_rows[$];

    function automatic void add_row(in_item_t it, logic k, status_t st, logic [7:0] bid);
        dir_row_t r;
        r.beat = it;
        r.has_known = k;
        r.known = '0;
        r.known.status = st;
        r.known.out_buffer_id = bid;
        directed_rows.push_back(r);
    endfunction

    function automatic void build_directed();
        in_item_t it;
        // Nothing is bound after reset, so recv and a clean frame find no socket.
        it = make_item(CMD_RECV, 16'hFFFF);
        add_row(it, 1'b1, ST_NOSOCK, 8'd0);
        it = good_frame(16'd0);
        add_row(it, 1'b1, ST_NOSOCK, it.buffer_id);
        it = make_item(CMD_BIND, 16'd0);
        add_row(it, 1'b1, ST_OK, 8'd0);
        add_row(it, 1'b1, ST_OK, 8'd0);                // rebind of a bound port
        it = make_item(CMD_BIND, 16'hFFFF);
        add_row(it, 1'b1, ST_OK, 8'd0);
        it = make_item(CMD_RECV, 16'd0);
        add_row(it, 1'b1, ST_EMPTY, 8'd0);
        it = make_item(CMD_NONE, 16'd0);
        add_row(it, 1'b1, ST_OTHER, 8'd0);
        // ARP frames at and below the minimum length.
        it = good_frame(16'd0); it.eth_type = TYPE_ARP; it.frame_len = 13'd42;
        add_row(it, 1'b1, ST_ARP, it.buffer_id);
        it.frame_len = 13'd41; it.buffer_id = 8'hFF;
        add_row(it, 1'b1, ST_SHORT, 8'hFF);
        it = good_frame(16'd0); it.eth_type = 16'hFFFF;
        add_row(it, 1'b1, ST_OTHER, it.buffer_id);
        // Short IP frames, with the non-UDP window between 34 and 41 bytes.
        it = good_frame(16'd0); it.frame_len = 13'd33;
        add_row(it, 1'b1, ST_SHORT, it.buffer_id);
        it.frame_len = 13'd34; it.ip_proto = 8'd6;
        add_row(it, 1'b1, ST_NOTUDP, it.buffer_id);
        it.ip_proto = PROTO_UDP; it.frame_len = 13'd41;
        add_row(it, 1'b1, ST_SHORT, it.buffer_id);
        it = good_frame(16'd0); it.ip_proto = 8'hFF;
        add_row(it, 1'b1, ST_NOTUDP, it.buffer_id);
        it = good_frame(16'd0); it.udp_length = 16'd7;
        add_row(it, 1'b1, ST_BADLEN, it.buffer_id);
        // Queued frames at length extremes, then pops with zero and full limits.
        it = good_frame(16'hFFFF); it.udp_length = 16'd8; it.frame_len = 13'd4096;
        add_row(it, 1'b1, ST_OK, 8'd0);
        it = good_frame(16'hFFFF); it.udp_length = 16'hFFFF; it.buffer_id = 8'hFF;
        it.source_ip = 32'hFFFF_FFFF; it.udp_src_port = 16'hFFFF;
        add_row(it, 1'b1, ST_OK, 8'd0);
        it = make_item(CMD_RECV, 16'hFFFF); it.max_len = 16'hFFFF;
        add_row(it, 1'b0, ST_OK, 8'd0);
        it.max_len = 16'd0;
        add_row(it, 1'b0, ST_OK, 8'd0);
        // Fill the table: fourteen more ports bind, the next one fails.
        for (int i = 1; i <= 14; i++)
        begin
            it = make_item(CMD_BIND, 16'(i));
            add_row(it, 1'b1, ST_OK, 8'd0);
        end
        it = make_item(CMD_BIND, 16'd100);
        add_row(it, 1'b1, ST_FULL, 8'd0);
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Mostly valid frames and recvs on bound ports, with some noise and binds.
    task automatic random_beats(int count);
        in_item_t it;
        logic [15:0] p;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            p = 16'($urandom_range(15));
            if ($urandom_range(9) == 0)
                p = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                it = good_frame(p);
                if ($urandom_range(7) == 0)
                    it.frame_len = 13'($urandom_range(8191));
                if ($urandom_range(11) == 0)
                    it.ip_proto = 8'($urandom);
                if ($urandom_range(11) == 0)
                    it.eth_type = ($urandom_range(1) == 0) ? TYPE_ARP : 16'($urandom);
                if ($urandom_range(15) == 0)
                    it.udp_length = 16'($urandom_range(7));
            end
            else if (pick < 90)
            begin
                it = make_item(CMD_RECV, p);
                if ($urandom_range(3) == 0)
                    it.max_len = 16'($urandom_range(20));
            end
            else if (pick < 97)
                it = make_item(CMD_BIND, p);
            else
                it = make_item(CMD_NONE, p);
            send_beat(it, 1'b0, '0);
        end
    endtask

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < SOCKETS; i++)
        begin
            sock_used[i] = 1'b0;
            sock_port[i] = '0;
            ring_head[i] = 0;
            ring_count[i] = 0;
        end
        for (int i = 0; i < 16; i++)
            status_hits[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, walked with no idling on either side.
        build_directed();
        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].has_known,
                      directed_rows[i].known);

        // The sender holds off here until every result has come back.
        wait_drained();

        random_beats(300);
        send_idle_pct = 80;
        random_beats(250);
        send_idle_pct = 0;
        recv_stall_pct = 80;
        random_beats(250);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        random_beats(280);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        $display("Covered %0d results: ok %0d, full %0d, no socket %0d, empty %0d, short %0d,",
                 results_seen, status_hits[ST_OK], status_hits[ST_FULL],
                 status_hits[ST_NOSOCK], status_hits[ST_EMPTY], status_hits[ST_SHORT]);
        $display("  not udp %0d, bad length %0d, queue full %0d, arp %0d, other %0d.",
                 status_hits[ST_NOTUDP], status_hits[ST_BADLEN], status_hits[ST_QFULL],
                 status_hits[ST_ARP], status_hits[ST_OTHER]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/udpdmx_pkg.sv
rtl/core/udpdmx_ctrl.sv
rtl/core/udpdmx_dp.sv
rtl/core/udp_port_demux_queues_unit.sv
dv/tb.sv
